// ===== rtl/hdrf_edge_partitioner_defines.svh =====
// assertion macros for the edge partitioner checker
`ifndef HDRF_EDGE_PARTITIONER_DEFINES_SVH
`define HDRF_EDGE_PARTITIONER_DEFINES_SVH

// clocked implication, disabled in reset
`define HDRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check kept alive while reset is held
`define HDRF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdrf_pkg
// shared widths, register indexes and helpers for the edge partitioner
// ----------------------------------------------------------------------------
package hdrf_pkg;
	localparam int VTX_W        = 16;
	localparam int VTX_COUNT    = 1 << VTX_W;
	localparam int PART_W       = 4;
	localparam int NUM_PARTS    = 1 << PART_W;
	localparam int DEG_W        = 32;
	localparam int LOAD_W       = 32;
	localparam int FRAC_W       = 12;
	localparam int NUM_W        = LOAD_W + 2 * FRAC_W;
	localparam int DEN_W        = LOAD_W + FRAC_W + 1;
	localparam int DCNT_W       = $clog2(NUM_W);
	localparam int REP_W        = FRAC_W + 2;
	localparam int PROD_W       = 64;
	localparam int SCORE_W      = PROD_W - FRAC_W + 1;
	localparam int BW_W         = 16;
	localparam int EPS_W        = 16;
	localparam int HALF_W       = NUM_W / 2;
	localparam int MULP_W       = BW_W + HALF_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_WEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CAP        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_EPSILON = 2'd2;

	localparam logic [BW_W-1:0]   BW_RESET   = 16'd4096;
	localparam logic [LOAD_W-1:0] CAP_RESET  = '1;
	localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd4096;
	localparam logic [REP_W-1:0]  REP_FULL   = 14'd8192;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction
endpackage

// ===== rtl/hdrf_ram.sv =====
// ----------------------------------------------------------------------------
// hdrf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hdrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/hdrf_div.sv =====
// ----------------------------------------------------------------------------
// hdrf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hdrf_div import hdrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/hdrf_edge_partitioner.sv =====
// between request and result, two passes of the shared bit-serial divider give the
// replication fractions, and each open partition adds one more pass for the
// balance term once an edge has been placed
// edges do not overlap: a new edge is taken only after the last result has left
// reset: asynchronous, then a sweep over every vertex clears the degree and mirror
// memories before the first edge is taken; config writes are taken throughout
// ----------------------------------------------------------------------------
// hdrf_edge_partitioner
// streaming edge partitioner, sequencer around a shared divider and multiplier
// ----------------------------------------------------------------------------
module hdrf_edge_partitioner import hdrf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VTX_W-1:0]      src_vertex,
	input  logic [VTX_W-1:0]      dst_vertex,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PART_W-1:0]     partition,
	output logic                  no_room
);
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RDU, ST_RDV, ST_GETV, ST_SUM, ST_DIVU, ST_DIVV, ST_DEN,
		ST_PART, ST_DIVB, ST_MUL0, ST_MUL1, ST_CMP, ST_UPD, ST_UPD2, ST_MIN, ST_OUT
	} state_t;

	state_t              state_q;
	logic [VTX_W-1:0]    clr_q;
	logic [VTX_W-1:0]    u_q, v_q;
	logic [DEG_W-1:0]    du_q, dv_q;
	logic [NUM_PARTS-1:0] mu_q, mv_q;
	logic [FRAC_W:0]     fracu_q, fracv_q;
	logic [DEN_W-1:0]    denb_q;
	logic [PART_W-1:0]   idx_q, chosen_q;
	logic                found_q;
	logic [SCORE_W-1:0]  best_q;
	logic [NUM_W-1:0]    bal_q;
	logic [PROD_W-1:0]   prod_q;
	logic [LOAD_W-1:0]   loads_q [NUM_PARTS];
	logic [LOAD_W-1:0]   hi_q, lo_q, min_q;
	logic                known_q;
	logic [BW_W-1:0]     bw_q;
	logic [LOAD_W-1:0]   cap_q;
	logic [EPS_W-1:0]    eps_q;

	logic                deg_we, mir_we;
	logic [VTX_W-1:0]    waddr, raddr;
	logic [DEG_W-1:0]    deg_wdata, deg_rdata;
	logic [NUM_PARTS-1:0] mir_wdata, mir_rdata, part_bit;
	logic                div_start, div_done;
	logic [NUM_W-1:0]    div_num, div_quo;
	logic [DEN_W-1:0]    div_den;
	logic [DEG_W:0]      deg_sum;
	logic [LOAD_W-1:0]   cur_load, new_load, diff;
	logic [HALF_W-1:0]   mul_b;
	logic [MULP_W-1:0]   mul_p;
	logic [REP_W-1:0]    rep_u, rep_v;
	logic [REP_W:0]      rep;
	logic [SCORE_W-1:0]  score;
	logic                better, last;
	logic [DEN_W-1:0]    den_calc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign partition = chosen_q;
	assign no_room   = !found_q;

	assign cur_load = loads_q[idx_q];
	assign new_load = sat_inc(cur_load);
	assign diff     = hi_q - cur_load;
	assign deg_sum  = {1'b0, du_q} + {1'b0, dv_q};
	assign part_bit = NUM_PARTS'(1) << chosen_q;
	assign last     = (idx_q == PART_W'(NUM_PARTS - 1));
	assign mul_b    = (state_q == ST_MUL0) ? bal_q[HALF_W-1:0] : bal_q[NUM_W-1:HALF_W];
	assign mul_p    = bw_q * mul_b;
	assign rep_u    = REP_FULL - {1'b0, fracu_q};
	assign rep_v    = REP_FULL - {1'b0, fracv_q};
	assign rep      = (mu_q[idx_q] ? {1'b0, rep_u} : '0) + (mv_q[idx_q] ? {1'b0, rep_v} : '0);
	assign score    = {1'b0, prod_q[PROD_W-1:FRAC_W]} + SCORE_W'(rep);
	assign better   = score > best_q;
	assign den_calc = DEN_W'(eps_q)
		+ ((hi_q > lo_q) ? {1'b0, hi_q - lo_q, {FRAC_W{1'b0}}} : '0);

	always_comb begin
		unique case (state_q)
			ST_SUM:  div_num = NUM_W'({du_q, {FRAC_W{1'b0}}});
			ST_DIVU: div_num = NUM_W'({dv_q, {FRAC_W{1'b0}}});
			default: div_num = {diff, {(2 * FRAC_W){1'b0}}};
		endcase
		div_den   = (state_q == ST_PART) ? denb_q : DEN_W'(deg_sum);
		div_start = (state_q == ST_SUM) || (state_q == ST_DIVU && div_done)
			|| (state_q == ST_PART && cur_load < cap_q && cur_load <= hi_q
			&& known_q && denb_q != '0);
	end

	always_comb begin
		raddr     = (state_q == ST_IDLE) ? src_vertex : v_q;
		deg_we    = 1'b0;
		mir_we    = 1'b0;
		waddr     = u_q;
		deg_wdata = sat_inc(deg_rdata);
		mir_wdata = mu_q | part_bit;
		unique case (state_q)
			ST_CLEAR: begin
				deg_we    = 1'b1;
				mir_we    = 1'b1;
				waddr     = clr_q;
				deg_wdata = '0;
				mir_wdata = '0;
			end
			ST_RDU:  deg_we = 1'b1;
			ST_GETV: begin
				deg_we = 1'b1;
				waddr  = v_q;
			end
			ST_UPD:  mir_we = 1'b1;
			ST_UPD2: begin
				mir_we    = 1'b1;
				waddr     = v_q;
				mir_wdata = mv_q | part_bit;
			end
			default: ;
		endcase
	end

	hdrf_ram #(.WIDTH(DEG_W), .DEPTH(VTX_COUNT)) u_deg_ram (
		.clk(clk), .we(deg_we), .waddr(waddr), .wdata(deg_wdata),
		.raddr(raddr), .rdata(deg_rdata)
	);

	hdrf_ram #(.WIDTH(NUM_PARTS), .DEPTH(VTX_COUNT)) u_mir_ram (
		.clk(clk), .we(mir_we), .waddr(waddr), .wdata(mir_wdata),
		.raddr(raddr), .rdata(mir_rdata)
	);

	hdrf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= BW_RESET;
			cap_q <= CAP_RESET;
			eps_q <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BALANCE_WEIGHT:  bw_q  <= cfg_data[BW_W-1:0];
				CFG_LOAD_CAP:        cap_q <= cfg_data[LOAD_W-1:0];
				CFG_BALANCE_EPSILON: eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			idx_q    <= '0;
			chosen_q <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			known_q  <= 1'b0;
			for (int i = 0; i < NUM_PARTS; i++) begin
				loads_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_RDU;
						idx_q    <= '0;
						chosen_q <= '0;
						found_q  <= 1'b0;
						best_q   <= '0;
					end
				end
				ST_RDU:  state_q <= ST_RDV;
				ST_RDV:  state_q <= ST_GETV;
				ST_GETV: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DIVU;
				ST_DIVU: if (div_done) begin
					state_q <= ST_DIVV;
				end
				ST_DIVV: if (div_done) begin
					state_q <= ST_DEN;
				end
				ST_DEN:  state_q <= ST_PART;
				ST_PART: begin
					if (cur_load >= cap_q) begin
						if (last) begin
							idx_q   <= chosen_q;
							state_q <= ST_UPD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (div_start) begin
						state_q <= ST_DIVB;
					end else begin
						state_q <= ST_MUL0;
					end
				end
				ST_DIVB: if (div_done) begin
					state_q <= ST_MUL0;
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_CMP;
				ST_CMP: begin
					if (better) begin
						best_q   <= score;
						chosen_q <= idx_q;
						found_q  <= 1'b1;
					end
					if (last) begin
						idx_q   <= better ? idx_q : chosen_q;
						state_q <= ST_UPD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_PART;
					end
				end
				ST_UPD: begin
					loads_q[idx_q] <= new_load;
					if (new_load > hi_q) begin
						hi_q <= new_load;
					end
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					idx_q   <= '0;
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					if (last) begin
						lo_q    <= (cur_load < min_q) ? cur_load : min_q;
						known_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_OUT: if (!out_stall) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			u_q <= src_vertex;
			v_q <= dst_vertex;
		end
		if (state_q == ST_RDU) begin
			du_q <= sat_inc(deg_rdata);
			mu_q <= mir_rdata;
		end
		if (state_q == ST_GETV) begin
			dv_q <= sat_inc(deg_rdata);
			mv_q <= mir_rdata;
		end
		if (state_q == ST_DIVU && div_done) begin
			fracu_q <= div_quo[FRAC_W:0];
		end
		if (state_q == ST_DIVV && div_done) begin
			fracv_q <= div_quo[FRAC_W:0];
		end
		if (state_q == ST_DEN) begin
			denb_q <= den_calc;
		end
		if (state_q == ST_PART) begin
			if (cur_load > hi_q || (known_q && denb_q == '0)) begin
				bal_q <= '0;
			end else begin
				bal_q <= NUM_W'({diff, {FRAC_W{1'b0}}});
			end
		end
		if (state_q == ST_DIVB && div_done) begin
			bal_q <= div_quo;
		end
		if (state_q == ST_MUL0) begin
			prod_q <= PROD_W'(mul_p);
		end
		if (state_q == ST_MUL1) begin
			prod_q <= prod_q + {mul_p[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
		end
		if (state_q == ST_MIN) begin
			if (idx_q == '0 || cur_load < min_q) begin
				min_q <= cur_load;
			end
		end
	end
endmodule

// ===== rtl/hdrf_chk.sv =====
// ----------------------------------------------------------------------------
// hdrf_chk
// port level checks for the edge partitioner, bound to the top level
// ----------------------------------------------------------------------------
`include "hdrf_edge_partitioner_defines.svh"

module hdrf_chk import hdrf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PART_W-1:0] partition,
	input logic              no_room
);
	`HDRF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`HDRF_ASSERT(a_no_room_part, out_valid && no_room |-> partition == '0, "no_room with nonzero partition")
	`HDRF_ASSERT(a_busy_after, in_valid && !in_stall |=> in_stall && !out_valid, "request taken while busy")
	`HDRF_ASSERT(a_out_blocks, out_valid |-> in_stall, "request open while result pending")
	`HDRF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result shown in reset")
endmodule

bind hdrf_edge_partitioner hdrf_chk u_hdrf_chk (.*);
